// ===== design/ilfc_pkg.sv =====
package ilfc_pkg;

    localparam int unsigned DefaultDepth = 512;

    localparam logic signed [31:0] IntegLimit     = 32'sd262144000;
    localparam logic signed [33:0] RiseLimit      = 34'sd262144;
    localparam logic signed [33:0] FallLimit      = -34'sd655360;
    localparam logic signed [33:0] LateRiseLimit  = 34'sd65536;
    localparam logic signed [32:0] EarlyTargetLim = 33'sd458752;
    localparam logic signed [31:0] EarlyCeil      = 32'sd1092267;
    localparam logic signed [31:0] LagHighEdge    = -32'sd131072;
    localparam logic signed [31:0] LagLowEdge     = 32'sd131072;

    localparam logic [1:0] MarkNone  = 2'd0;
    localparam logic [1:0] MarkLearn = 2'd1;

    localparam logic [1:0] RegProp  = 2'd0;
    localparam logic [1:0] RegDeriv = 2'd1;
    localparam logic [1:0] RegInteg = 2'd2;
    localparam logic [1:0] RegLen   = 2'd3;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
        else if (v < -66'sh0_8000_0000) r = 32'sh8000_0000;
        else r = v[31:0];
        return r;
    endfunction

endpackage

// ===== design/ilfc_ram.sv =====
module ilfc_ram #(
    parameter int unsigned Width = 32,
    parameter int unsigned Depth = 512
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);

    logic [Width-1:0] mem [Depth];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== design/iterative_learning_force_control_core.sv =====
// Channel  Ports                                   Direction
// s_       force_target/measured, step_mark, index  in  (valid/ready)
// m_       drive_force, sample_count                out (valid/ready)
// cfg      cfg_we, cfg_index, cfg_data               in  (write only)
// An ordinary sample passes through the shared multiplier before its result is valid.
// The next word is accepted only after the result is taken. A learning copy clears
// the trace from the sample index up to the profile length, then copies the trace
// into the profile. After reset a clearing pass writes zero to every profile entry,
// and no word is accepted during it. The input waits while a result is not taken.
module iterative_learning_force_control_core
    import ilfc_pkg::*;
#(
    parameter int unsigned Depth = DefaultDepth
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_force_target,
    input  logic signed [31:0] s_force_measured,
    input  logic [1:0]         s_step_mark,
    input  logic [9:0]         s_stance_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_drive_force,
    output logic [9:0]         m_sample_count
);

    localparam int unsigned Aw = $clog2(Depth);
    localparam int unsigned Iw = $clog2(Depth + 1);

    typedef enum logic [13:0] {
        ST_CLEAR = 14'b00000000000001,
        ST_IDLE  = 14'b00000000000010,
        ST_MULP  = 14'b00000000000100,
        ST_MULD  = 14'b00000000001000,
        ST_MULI  = 14'b00000000010000,
        ST_SUM   = 14'b00000000100000,
        ST_ZERO  = 14'b00000001000000,
        ST_CRD   = 14'b00000010000000,
        ST_CWR   = 14'b00000100000000,
        ST_FIX   = 14'b00001000000000,
        ST_RD    = 14'b00010000000000,
        ST_ADD   = 14'b00100000000000,
        ST_LIM   = 14'b01000000000000,
        ST_OUT   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [31:0] kp_reg, kd_reg, ki_reg;
    logic [9:0]         len_reg;
    logic signed [31:0] tgt_reg, err_reg, diff_reg, integ_reg;
    logic [1:0]         mark_reg;
    logic [9:0]         stance_reg;
    logic signed [31:0] prev_err_reg, err_int_reg, prev_drive_reg;
    logic [47:0]        tot_reg, prior_tot_reg;
    logic [Iw-1:0]      idx_reg;
    logic [1:0]         step_reg, lag_reg;
    logic signed [47:0] acc_reg;
    logic signed [31:0] cmd_reg, drive_reg;
    logic [Iw-1:0]      cnt_reg;
    logic [Iw-1:0]      copy_len_reg;
    logic signed [31:0] ent1_reg;
    logic signed [31:0] out_drive_reg;
    logic [9:0]         out_cnt_reg;
    logic               out_valid_reg;

    // Trace and profile memories.
    logic          tr_we, pr_we;
    logic [Aw-1:0] tr_wa, tr_ra, pr_wa, pr_ra;
    logic [31:0]   tr_wd, tr_rd, pr_wd, pr_rd;

    ilfc_ram #(.Width(32), .Depth(Depth)) u_trace (
        .aclk(aclk), .wr_en(tr_we), .wr_addr(tr_wa), .wr_data(tr_wd),
        .rd_addr(tr_ra), .rd_data(tr_rd)
    );
    ilfc_ram #(.Width(32), .Depth(Depth)) u_profile (
        .aclk(aclk), .wr_en(pr_we), .wr_addr(pr_wa), .wr_data(pr_wd),
        .rd_addr(pr_ra), .rd_data(pr_rd)
    );

    // Shared multiplier: one operand pair selected by state.
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod;
    logic signed [47:0] prod_sh;
    always_comb begin
        case (state_reg)
            ST_MULP: begin mul_a = kp_reg; mul_b = err_reg;   end
            ST_MULD: begin mul_a = kd_reg; mul_b = diff_reg;  end
            default: begin mul_a = ki_reg; mul_b = integ_reg; end
        endcase
        prod    = mul_a * mul_b;
        prod_sh = prod[63:16];
    end

    // Input-side arithmetic on the accepted word.
    logic signed [32:0] err_w, diff_w, integ_w;
    logic signed [31:0] err_s, diff_s, integ_c;
    always_comb begin
        err_w  = 33'(s_force_measured) - 33'(s_force_target);
        err_s  = sat32(66'(err_w));
        diff_w = 33'(err_s) - 33'(prev_err_reg);
        diff_s = sat32(66'(diff_w));
        integ_w = 33'(err_int_reg) + 33'(err_s);
        if (integ_w > 33'(IntegLimit)) integ_c = IntegLimit;
        else if (integ_w < -33'(IntegLimit)) integ_c = -IntegLimit;
        else integ_c = integ_w[31:0];
    end

    logic accept;
    assign s_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign accept  = s_valid && s_ready;

    // Read address of the profile, saturated at the last entry.
    logic [Iw:0] rd_sum;
    logic [Aw-1:0] prof_addr;
    always_comb begin
        rd_sum = (Iw+1)'(idx_reg) + (Iw+1)'(lag_reg);
        prof_addr = (rd_sum > (Iw+1)'(Depth - 1)) ? Aw'(Depth - 1) : rd_sum[Aw-1:0];
    end

    // Limit stage arithmetic.
    logic signed [33:0] dlt;
    logic signed [31:0] lim_a, lim_b, lim_c;
    logic signed [15:0] idx_s, st_s;
    logic               early, late, edge3;
    always_comb begin
        idx_s = 16'(idx_reg);
        st_s  = 16'(stance_reg);
        dlt = 34'(drive_reg) - 34'(prev_drive_reg);
        lim_a = drive_reg;
        if (dlt > RiseLimit) lim_a = sat32(66'(prev_drive_reg) + 66'(RiseLimit));
        dlt = 34'(lim_a) - 34'(prev_drive_reg);
        lim_b = lim_a;
        if (dlt < FallLimit) lim_b = sat32(66'(prev_drive_reg) + 66'(FallLimit));
        early = (idx_s < st_s - 16'sd6) && (33'(tgt_reg) < EarlyTargetLim);
        late  = idx_s > st_s + 16'sd25;
        edge3 = idx_s == st_s + 16'sd3;
        lim_c = lim_b;
        if (early) begin
            if (lim_c > EarlyCeil) lim_c = EarlyCeil;
            if (lim_c < 0) lim_c = '0;
        end
        dlt = 34'(lim_c) - 34'(prev_drive_reg);
        if (late && dlt > LateRiseLimit)
            lim_c = sat32(66'(prev_drive_reg) + 66'(LateRiseLimit));
    end

    logic [48:0] tot_sum;
    logic [31:0] mag;
    assign mag = err_reg[31] ? 32'(-33'(err_reg)) : err_reg;
    assign tot_sum = 49'(tot_reg) + 49'(mag);

    // Memory ports, driven by state.
    always_comb begin
        tr_we = 1'b0; tr_wa = cnt_reg[Aw-1:0]; tr_wd = '0;
        tr_ra = cnt_reg[Aw-1:0];
        pr_we = 1'b0; pr_wa = cnt_reg[Aw-1:0]; pr_wd = tr_rd;
        pr_ra = prof_addr;
        case (state_reg)
            ST_CLEAR: begin pr_we = 1'b1; pr_wd = '0; end
            ST_ZERO: begin
                // Clear the unused tail of the trace; fetch profile entry one meanwhile.
                tr_we = cnt_reg < copy_len_reg;
                pr_ra = Aw'(1);
            end
            ST_CWR: begin
                pr_we = 1'b1;
                pr_wa = Aw'(cnt_reg - Iw'(1));
            end
            ST_FIX: begin
                pr_we = 1'b1; pr_wa = '0; pr_wd = ent1_reg;
            end
            ST_LIM: begin
                tr_we = idx_reg < Iw'(Depth);
                tr_wa = idx_reg[Aw-1:0];
                tr_wd = lim_c;
            end
            default: ;
        endcase
    end

    // Sequencer and datapath registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            kp_reg <= '0; kd_reg <= '0; ki_reg <= '0; len_reg <= 10'd500;
            prev_err_reg <= '0; err_int_reg <= '0; prev_drive_reg <= '0;
            tot_reg <= '0; prior_tot_reg <= '0; idx_reg <= '0;
            step_reg <= '0; lag_reg <= 2'd2; cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    RegProp:  kp_reg  <= cfg_data;
                    RegDeriv: kd_reg  <= cfg_data;
                    RegInteg: ki_reg  <= cfg_data;
                    RegLen:   len_reg <= cfg_data[9:0];
                    default: ;
                endcase
            end
            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR: cnt_reg <= cnt_reg + Iw'(1);
                ST_IDLE: if (accept) begin
                    tgt_reg <= s_force_target; err_reg <= err_s; diff_reg <= diff_s;
                    integ_reg <= integ_c; prev_err_reg <= err_s;
                    err_int_reg <= integ_c; mark_reg <= s_step_mark;
                    stance_reg <= s_stance_index;
                    copy_len_reg <= (32'(len_reg) > 32'(Depth)) ? Iw'(Depth) : Iw'(len_reg);
                end
                ST_MULP: acc_reg <= prod_sh;
                ST_MULD: acc_reg <= acc_reg + prod_sh;
                ST_MULI: acc_reg <= acc_reg + prod_sh;
                ST_SUM: begin
                    cmd_reg <= sat32(-66'(acc_reg));
                    cnt_reg <= idx_reg;
                    if (mark_reg != MarkNone && !(mark_reg == MarkLearn
                            && prior_tot_reg > tot_reg)) begin
                        prior_tot_reg <= tot_reg; err_int_reg <= '0;
                        idx_reg <= '0; tot_reg <= '0;
                        if (step_reg != 2'd3) step_reg <= step_reg + 2'd1;
                    end
                end
                ST_ZERO: begin
                    if (cnt_reg >= copy_len_reg) cnt_reg <= '0;
                    else cnt_reg <= cnt_reg + Iw'(1);
                end
                ST_CRD: begin
                    // Old entry one stands unless the copy reaches it.
                    ent1_reg <= pr_rd;
                    cnt_reg <= cnt_reg + Iw'(1);
                end
                ST_CWR: begin
                    cnt_reg <= cnt_reg + Iw'(1);
                    if (cnt_reg == Iw'(2)) ent1_reg <= tr_rd;
                end
                ST_FIX: begin
                    prior_tot_reg <= tot_reg; err_int_reg <= '0;
                    idx_reg <= '0; tot_reg <= '0;
                    if (step_reg != 2'd3) step_reg <= step_reg + 2'd1;
                end
                ST_ADD: begin
                    if (step_reg == 2'd3) begin
                        drive_reg <= sat32(66'($signed(pr_rd)) + 66'(cmd_reg));
                        tot_reg <= tot_sum[48] ? 48'hFFFF_FFFF_FFFF : tot_sum[47:0];
                    end else begin
                        drive_reg <= cmd_reg;
                    end
                end
                ST_LIM: begin
                    prev_drive_reg <= lim_c;
                    out_drive_reg <= lim_c;
                    if (edge3) begin
                        if (err_reg > LagHighEdge) lag_reg <= 2'd0;
                        if (err_reg < LagLowEdge) lag_reg <= 2'd2;
                    end
                    if (idx_reg < Iw'(Depth)) idx_reg <= idx_reg + Iw'(1);
                end
                ST_OUT: begin
                    out_cnt_reg <= 10'(idx_reg);
                    out_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (cnt_reg == Iw'(Depth - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (accept) state_next = ST_MULP;
            ST_MULP:  state_next = ST_MULD;
            ST_MULD:  state_next = ST_MULI;
            ST_MULI:  state_next = ST_SUM;
            ST_SUM: begin
                if (mark_reg == MarkLearn && prior_tot_reg > tot_reg)
                    state_next = ST_ZERO;
                else
                    state_next = ST_RD;
            end
            ST_ZERO: if (cnt_reg >= copy_len_reg) state_next = ST_CRD;
            ST_CRD:  state_next = (copy_len_reg == '0) ? ST_FIX : ST_CWR;
            ST_CWR: state_next = (cnt_reg >= copy_len_reg) ? ST_FIX : ST_CWR;
            ST_FIX:  state_next = ST_RD;
            ST_RD:   state_next = ST_ADD;
            ST_ADD:  state_next = ST_LIM;
            ST_LIM:  state_next = ST_OUT;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid        = out_valid_reg;
    assign m_drive_force  = out_drive_reg;
    assign m_sample_count = out_cnt_reg;

endmodule
